[hdl/assert_macros.svh]
// assertion macros shared by the decoder modules
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, off while reset is asserted
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// concurrent check on the rising clock, also active during reset
`define ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("assertion failed");

`endif

[hdl/nec_ir_pkg.sv]
// types and constants of the nec ir interval decoder
// no dependencies
`timescale 1ns / 1ps

package nec_ir_pkg;

	// configuration port geometry
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CODE_W    = 32;
	localparam int CNT_W     = 7;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GLITCH_LIMIT  = 3'd0,
		REG_HEADER_LOW    = 3'd1,
		REG_HEADER_HIGH   = 3'd2,
		REG_REPEAT_LOW    = 3'd3,
		REG_REPEAT_HIGH   = 3'd4,
		REG_ONE_THRESHOLD = 3'd5,
		REG_HOLD_TIMEOUT  = 3'd6
	} reg_idx_t;

	// register reset values
	localparam logic [CFG_W-1:0] GLITCH_LIMIT_RST  = 16'd150;
	localparam logic [CFG_W-1:0] HEADER_LOW_RST    = 16'd18000;
	localparam logic [CFG_W-1:0] HEADER_HIGH_RST   = 16'd22500;
	localparam logic [CFG_W-1:0] REPEAT_LOW_RST    = 16'd15000;
	localparam logic [CFG_W-1:0] REPEAT_HIGH_RST   = 16'd18000;
	localparam logic [CFG_W-1:0] ONE_THRESHOLD_RST = 16'd2400;
	localparam logic [CFG_W-1:0] HOLD_TIMEOUT_RST  = 16'd200;

	// frame constants
	localparam logic [CNT_W-1:0] FRAME_INTERVALS = 7'd64;
	localparam logic [7:0]       CHECK_PATTERN   = 8'hFF;

	// result event codes
	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_FRAME  = 2'd1,
		EV_REPEAT = 2'd2
	} event_t;

	// configuration bundle
	typedef struct packed {
		logic [CFG_W-1:0] glitch_limit;
		logic [CFG_W-1:0] header_low;
		logic [CFG_W-1:0] header_high;
		logic [CFG_W-1:0] repeat_low;
		logic [CFG_W-1:0] repeat_high;
		logic [CFG_W-1:0] one_threshold;
		logic [CFG_W-1:0] hold_timeout;
	} cfg_t;

	// one result word
	typedef struct packed {
		event_t              event_res;
		logic [CODE_W-1:0]   code;
		logic                hold_active;
	} res_t;

endpackage

[hdl/nec_ir_interval_decoder.sv]
// nec ir interval decoder top: configuration registers, input register, decode core, result register; needs nec_ir_pkg
// a word taken into the input register passes through the decode core into the result register when stage 1 advances
// throughput: one word per cycle; the input stalls only while stage 1 and the result
// register both hold words and the result side stalls
// reset clears the decode state, hold and pipeline valids and loads the register defaults.
`timescale 1ns / 1ps

module nec_ir_interval_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [nec_ir_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [nec_ir_pkg::CFG_W-1:0]        cfg_data,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic                                command,
	input  logic [nec_ir_pkg::CFG_W-1:0]        interval,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic [1:0]                          event_res,
	output logic [nec_ir_pkg::CODE_W-1:0]       code,
	output logic                                hold_active
);
	import nec_ir_pkg::*;

	`include "assert_macros.svh"

	cfg_t               cfg;
	res_t               res_next;
	res_t               res_q;
	logic               res_valid_q;
	logic               valid_s1;
	logic               command_s1;
	logic [CFG_W-1:0]   interval_s1;
	logic               advance_s1;
	logic               accept;

	// configuration registers
	nec_ir_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshake: stage 1 moves on when the result register is free or drained
	assign advance_s1 = valid_s1 && (!res_valid_q || !res_stall);
	assign item_stall = valid_s1 && !advance_s1;
	assign accept     = item_valid && !item_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			command_s1  <= command;
			interval_s1 <= interval;
		end
	end

	// decode logic and state
	nec_ir_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (advance_s1),
		.command  (command_s1),
		.interval (interval_s1),
		.cfg      (cfg),
		.res      (res_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			res_q <= res_next;
		end
	end

	assign res_valid   = res_valid_q;
	assign event_res   = res_q.event_res;
	assign code        = res_q.code;
	assign hold_active = res_q.hold_active;

	// stall toward the source only while a word waits in stage 1
	`ASSERT_ALWAYS(a_stall_needs_word, item_stall |-> valid_s1)
	// a word that cannot move out of stage 1 stays there
	`ASSERT_CLK(a_s1_held, item_stall |=> valid_s1)
	// a repeat never reports an empty code
	`ASSERT_CLK(a_repeat_code,
		(res_valid_q && (res_q.event_res == EV_REPEAT)) |-> (res_q.code != '0))
	// an idle result carries no code
	`ASSERT_CLK(a_none_zero,
		(res_valid_q && (res_q.event_res == EV_NONE)) |-> (res_q.code == '0))

endmodule

[hdl/nec_ir_cfg.sv]
// configuration registers of the nec ir decoder
// depends on nec_ir_pkg
`timescale 1ns / 1ps

module nec_ir_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [nec_ir_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [nec_ir_pkg::CFG_W-1:0]        cfg_data,
	output nec_ir_pkg::cfg_t                    cfg
);
	import nec_ir_pkg::*;

	cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glitch_limit  <= GLITCH_LIMIT_RST;
			cfg_q.header_low    <= HEADER_LOW_RST;
			cfg_q.header_high   <= HEADER_HIGH_RST;
			cfg_q.repeat_low    <= REPEAT_LOW_RST;
			cfg_q.repeat_high   <= REPEAT_HIGH_RST;
			cfg_q.one_threshold <= ONE_THRESHOLD_RST;
			cfg_q.hold_timeout  <= HOLD_TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_GLITCH_LIMIT:  cfg_q.glitch_limit  <= cfg_data;
				REG_HEADER_LOW:    cfg_q.header_low    <= cfg_data;
				REG_HEADER_HIGH:   cfg_q.header_high   <= cfg_data;
				REG_REPEAT_LOW:    cfg_q.repeat_low    <= cfg_data;
				REG_REPEAT_HIGH:   cfg_q.repeat_high   <= cfg_data;
				REG_ONE_THRESHOLD: cfg_q.one_threshold <= cfg_data;
				REG_HOLD_TIMEOUT:  cfg_q.hold_timeout  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/nec_ir_core.sv]
// decode state and single-pass next-state logic of the nec ir decoder
// depends on nec_ir_pkg and assert_macros.svh
`timescale 1ns / 1ps

module nec_ir_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step_en,
	input  logic                           command,
	input  logic [nec_ir_pkg::CFG_W-1:0]   interval,
	input  nec_ir_pkg::cfg_t               cfg,
	output nec_ir_pkg::res_t               res
);
	import nec_ir_pkg::*;

	`include "assert_macros.svh"

	logic                collecting_q, collecting_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d, cnt_inc;
	logic [CODE_W-1:0]   shift_q, shift_d;
	logic [CODE_W-1:0]   last_q, last_d;
	logic                hold_q, hold_d;
	logic [CFG_W-1:0]    elapsed_q, elapsed_d, elapsed_inc;
	logic                in_repeat, in_header;

	// saturating millisecond count and interval counter step
	assign elapsed_inc = (elapsed_q != {CFG_W{1'b1}}) ? elapsed_q + 1'b1 : elapsed_q;
	assign cnt_inc     = cnt_q + 1'b1;

	// window compares for idle intervals
	assign in_repeat = (interval >= cfg.repeat_low) && (interval < cfg.repeat_high);
	assign in_header = (interval >= cfg.header_low) && (interval <= cfg.header_high);

	// next state and result for one word
	always_comb begin
		collecting_d  = collecting_q;
		cnt_d         = cnt_q;
		shift_d       = shift_q;
		last_d        = last_q;
		hold_d        = hold_q;
		elapsed_d     = elapsed_q;
		res.event_res = EV_NONE;
		res.code      = '0;

		if (command) begin
			elapsed_d = elapsed_inc;
			if (hold_q && (elapsed_inc > cfg.hold_timeout)) begin
				hold_d = 1'b0;
			end
		end else if (interval > cfg.glitch_limit) begin
			if (collecting_q) begin
				cnt_d = cnt_inc;
				// even intervals after the header carry the bits, lsb first
				if (!cnt_inc[0] && (interval > cfg.one_threshold)) begin
					shift_d[cnt_q[5:1]] = 1'b1;
				end
				if (cnt_inc >= FRAME_INTERVALS) begin
					if ((shift_d[23:16] ^ shift_d[31:24]) == CHECK_PATTERN) begin
						res.event_res = EV_FRAME;
						res.code      = shift_d;
						last_d        = shift_d;
						hold_d        = 1'b1;
						elapsed_d     = '0;
					end
					collecting_d = 1'b0;
					cnt_d        = '0;
				end
			end else if (in_repeat) begin
				// a zero last code means no frame seen yet
				if (last_q != '0) begin
					res.event_res = EV_REPEAT;
					res.code      = last_q;
					hold_d        = 1'b1;
					elapsed_d     = '0;
				end
			end else if (in_header) begin
				collecting_d = 1'b1;
				cnt_d        = '0;
				shift_d      = '0;
			end
		end

		res.hold_active = hold_d && (elapsed_d < cfg.hold_timeout);
	end

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			cnt_q        <= '0;
			shift_q      <= '0;
			last_q       <= '0;
			hold_q       <= 1'b0;
			elapsed_q    <= '0;
		end else if (step_en) begin
			collecting_q <= collecting_d;
			cnt_q        <= cnt_d;
			shift_q      <= shift_d;
			last_q       <= last_d;
			hold_q       <= hold_d;
			elapsed_q    <= elapsed_d;
		end
	end

	// idle keeps the interval count cleared
	`ASSERT_CLK(a_idle_cnt_clear, !collecting_q |-> (cnt_q == '0))
	// a stored code always passes the frame check or is still empty
	`ASSERT_CLK(a_last_code_ok,
		(last_q == '0) || ((last_q[23:16] ^ last_q[31:24]) == CHECK_PATTERN))

endmodule
